// ----- rtl/ffcr_pkg.sv -----
package ffcr_pkg;

    // Frame layout and markers.
    localparam int          FRAME_LENGTH_DEF = 16;
    localparam logic [7:0]  START_BYTE       = 8'hFF;
    localparam logic [7:0]  END_BYTE         = 8'hFE;

    // Byte positions inside a frame (the start byte sits at position 0).
    localparam int POS_ID      = 1;
    localparam int POS_MODE    = 2;
    localparam int POS_TARGET  = 3;
    localparam int POS_HOLD    = 4;
    localparam int POS_FAN     = 5;
    localparam int POS_FANONLY = 6;
    localparam int POS_FLOOR   = 7;
    localparam int POS_DUTY    = 8;
    localparam int POS_VOLUME  = 11;
    localparam int POS_REPEAT  = 12;
    localparam int POS_PRESET  = 13;
    localparam int POS_SOUND   = 14;
    localparam int POS_FIRST   = POS_ID;
    localparam int POS_LAST    = POS_SOUND;

    // Validation limits.
    localparam logic [7:0] ID_LIMIT    = 8'd50;
    localparam logic [7:0] MODE_USER   = 8'd1;
    localparam logic [7:0] MODE_PRESET = 8'd2;
    localparam logic [7:0] FLOOR_MIN   = 8'd10;
    localparam logic [7:0] FLOOR_MAX   = 8'd30;
    localparam logic [7:0] HOLD_MAX    = 8'd60;
    localparam logic [7:0] VOLUME_MARK = 8'hF0;

    // Result kinds.
    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_MORE = 2'd1;
    localparam logic [1:0] KIND_LAST = 2'd2;

    // Job codes carried through the queue.
    localparam logic [1:0] JOB_CMD = 2'd0;
    localparam logic [1:0] JOB_VOL = 2'd1;
    localparam logic [1:0] JOB_ONE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_OWN_ID    = 2'd0;
    localparam logic [1:0] REG_TEMP_LOW  = 2'd1;
    localparam logic [1:0] REG_TEMP_HIGH = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] run_mode;
        logic [7:0] heat_target;
        logic [5:0] hold_seconds;
        logic [7:0] fan_level;
        logic       fan_alone;
        logic [4:0] cool_floor;
        logic [7:0] heater_duty;
        logic       repeat_on;
        logic [7:0] preset_number;
        logic [7:0] sound_number;
    } cmd_t;

    typedef struct packed {
        logic [1:0] job;
        logic [7:0] audio;
        cmd_t       cmd;
    } job_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] audio_byte;
        cmd_t       cmd;
    } res_t;

    typedef struct packed {
        logic [5:0] own_id;
        logic [7:0] temp_low;
        logic [7:0] temp_high;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } q_stat_t;

endpackage

// ----- rtl/ffcr_front.sv -----
module ffcr_front #(
    parameter int FRAME_LENGTH = ffcr_pkg::FRAME_LENGTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_ready,
    input  logic [7:0]        rx_byte,
    input  ffcr_pkg::cfg_t    cfg,
    input  ffcr_pkg::q_stat_t q_stat,
    output logic              push,
    output ffcr_pkg::job_t    push_job
);
    import ffcr_pkg::*;

    localparam int                IDX_W    = $clog2(FRAME_LENGTH);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(FRAME_LENGTH - 1);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [7:0]       field_reg [POS_LAST:POS_FIRST];

    logic       accept;
    logic       at_last;
    logic [7:0] id_b, mode_b, tgt_b, hold_b, fan_b, floor_b, vol_b, preset_b, snd_b;
    logic       fan_only, is_reset, pass, sound_only;
    logic       id_ok, mode_ok, temp_ok, floor_ok, hold_ok;
    logic [7:0] track_byte;

    assign at_last  = (idx_reg == LAST_IDX);
    // Only the closing byte can create a job, so only it waits for queue room.
    assign rx_ready = !(at_last && q_stat.full);
    assign accept   = rx_valid && rx_ready;

    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            if (idx_reg == '0)
            begin
                if (rx_byte == START_BYTE)
                begin
                    idx_next = IDX_W'(1);
                end
            end
            else if (at_last)
            begin
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = POS_FIRST; p <= POS_LAST; p++)
        begin
            if (accept && idx_reg == IDX_W'(p))
            begin
                field_reg[p] <= rx_byte;
            end
        end
    end

    assign id_b     = field_reg[POS_ID];
    assign mode_b   = field_reg[POS_MODE];
    assign tgt_b    = field_reg[POS_TARGET];
    assign hold_b   = field_reg[POS_HOLD];
    assign fan_b    = field_reg[POS_FAN];
    assign floor_b  = field_reg[POS_FLOOR];
    assign vol_b    = field_reg[POS_VOLUME];
    assign preset_b = field_reg[POS_PRESET];
    assign snd_b    = field_reg[POS_SOUND];

    assign fan_only = (field_reg[POS_FANONLY] == 8'd1);
    assign is_reset = !fan_only && fan_b == 8'd0 && tgt_b == 8'd0;

    assign id_ok    = (id_b < ID_LIMIT) && (id_b == {2'b00, cfg.own_id});
    assign mode_ok  = (mode_b <= MODE_PRESET);
    assign temp_ok  = !(mode_b == MODE_USER && !fan_only && !is_reset &&
                        (tgt_b < cfg.temp_low || tgt_b > cfg.temp_high));
    assign floor_ok = (floor_b == 8'd0) || (floor_b inside {[FLOOR_MIN:FLOOR_MAX]});
    assign hold_ok  = (hold_b <= HOLD_MAX);
    assign pass     = id_ok && mode_ok && temp_ok && floor_ok && hold_ok;

    assign sound_only = mode_b == MODE_PRESET && preset_b == 8'd0 && tgt_b == 8'd0 &&
                        hold_b == 8'd0 && fan_b == 8'd0 && floor_b == 8'd0;

    // Track command: two codes per sound, the second one selects looping.
    assign track_byte = ((snd_b - 8'd1) << 1) + 8'd1 + {7'd0, field_reg[POS_REPEAT] == 8'd1};

    assign push = accept && at_last && rx_byte == END_BYTE && pass;

    always_comb
    begin
        push_job.cmd.run_mode      = mode_b[1:0];
        push_job.cmd.heat_target   = tgt_b;
        push_job.cmd.hold_seconds  = hold_b[5:0];
        push_job.cmd.fan_level     = fan_b;
        push_job.cmd.fan_alone     = fan_only;
        push_job.cmd.cool_floor    = floor_b[4:0];
        push_job.cmd.heater_duty   = field_reg[POS_DUTY];
        push_job.cmd.repeat_on     = (field_reg[POS_REPEAT] == 8'd1);
        push_job.cmd.preset_number = preset_b;
        push_job.cmd.sound_number  = snd_b;
        if (!sound_only)
        begin
            push_job.job   = JOB_CMD;
            push_job.audio = 8'd0;
        end
        else if (vol_b != 8'd0)
        begin
            push_job.job   = JOB_VOL;
            push_job.audio = vol_b;
        end
        else
        begin
            push_job.job   = JOB_ONE;
            push_job.audio = (snd_b == 8'd0) ? 8'd0 : track_byte;
        end
    end

endmodule

// ----- rtl/ffcr_queue.sv -----
module ffcr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ffcr_pkg::job_t    push_job,
    input  logic              pop,
    output ffcr_pkg::job_t    head_job,
    output ffcr_pkg::q_stat_t q_stat
);
    import ffcr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] r;
        r = (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
        return r;
    endfunction

    assign q_stat.full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.nonempty = (count_reg != '0);
    assign head_job        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/ffcr_back.sv -----
module ffcr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ffcr_pkg::job_t    head_job,
    input  ffcr_pkg::q_stat_t q_stat,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output ffcr_pkg::res_t    out_res
);
    import ffcr_pkg::*;

    logic       valid_reg, valid_next;
    logic       phase_reg, phase_next;
    logic [7:0] vol_reg, vol_next;
    res_t       res_reg, res_next;
    logic       load;

    // The output register takes a new beat whenever it is empty or being drained.
    assign load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        vol_next   = vol_reg;
        res_next   = res_reg;
        pop        = 1'b0;
        if (load)
        begin
            if (phase_reg)
            begin
                valid_next          = 1'b1;
                phase_next          = 1'b0;
                res_next.kind       = KIND_LAST;
                res_next.audio_byte = vol_reg;
                res_next.cmd        = '0;
            end
            else if (q_stat.nonempty)
            begin
                pop        = 1'b1;
                valid_next = 1'b1;
                case (head_job.job)
                    JOB_VOL:
                    begin
                        phase_next          = 1'b1;
                        vol_next            = head_job.audio;
                        res_next.kind       = KIND_MORE;
                        res_next.audio_byte = VOLUME_MARK;
                        res_next.cmd        = '0;
                    end
                    JOB_ONE:
                    begin
                        res_next.kind       = KIND_LAST;
                        res_next.audio_byte = head_job.audio;
                        res_next.cmd        = '0;
                    end
                    default:
                    begin
                        res_next.kind       = KIND_CMD;
                        res_next.audio_byte = 8'd0;
                        res_next.cmd        = head_job.cmd;
                    end
                endcase
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vol_reg <= vol_next;
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- rtl/fixed_frame_command_receiver_core.sv -----
// Channel | Direction | Ports                                      | Beat
// --------+-----------+--------------------------------------------+---------------------------
// rx      | in        | rx_valid, rx_ready, rx_byte                | one received serial byte
// out     | out       | out_valid, out_ready, kind ... sound       | one command or audio result
// cfg     | in        | cfg_valid, cfg_ready, cfg_index, cfg_data  | one register write
//
// The receiver takes one rx beat per cycle while rx_ready is high. A frame's verdict is formed
// in the cycle its end byte is taken; the job then moves via the queue to the output register.
// Results leave at up to one per cycle while out_ready is high; a volume frame yields two
// back-to-back beats. Reset clears the byte counter, the queue and the output register;
// no clearing pass runs. rx_ready drops only on the final byte of a frame while the
// two-entry job queue is full, which happens only when the out channel is held off for a long time.
module fixed_frame_command_receiver_core #(
    parameter int FRAME_LENGTH = ffcr_pkg::FRAME_LENGTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] audio_byte,
    output logic [1:0] run_mode,
    output logic [7:0] heat_target,
    output logic [5:0] hold_seconds,
    output logic [7:0] fan_level,
    output logic       fan_alone,
    output logic [4:0] cool_floor,
    output logic [7:0] heater_duty,
    output logic       repeat_on,
    output logic [7:0] preset_number,
    output logic [7:0] sound_number
);
    import ffcr_pkg::*;

    // Configuration registers. Writes are taken at any time; an unknown index is ignored.
    logic [5:0] own_id_reg;
    logic [7:0] temp_low_reg;
    logic [7:0] temp_high_reg;
    cfg_t       cfg;

    // Front to queue to back.
    logic    push;
    job_t    push_job;
    logic    pop;
    job_t    head_job;
    q_stat_t q_stat;
    res_t    out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg    <= 6'd1;
            temp_low_reg  <= 8'd40;
            temp_high_reg <= 8'd50;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OWN_ID:    own_id_reg    <= cfg_data[5:0];
                REG_TEMP_LOW:  temp_low_reg  <= cfg_data;
                REG_TEMP_HIGH: temp_high_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.own_id    = own_id_reg;
    assign cfg.temp_low  = temp_low_reg;
    assign cfg.temp_high = temp_high_reg;

    // The front collects the frame and judges it as the end byte goes by.
    ffcr_front #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_byte  (rx_byte),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    // Accepted frames wait here so that a stalled output blocks byte intake only once the queue is full.
    ffcr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    // The back expands each job into one or two result beats.
    ffcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind          = out_res.kind;
    assign audio_byte    = out_res.audio_byte;
    assign run_mode      = out_res.cmd.run_mode;
    assign heat_target   = out_res.cmd.heat_target;
    assign hold_seconds  = out_res.cmd.hold_seconds;
    assign fan_level     = out_res.cmd.fan_level;
    assign fan_alone     = out_res.cmd.fan_alone;
    assign cool_floor    = out_res.cmd.cool_floor;
    assign heater_duty   = out_res.cmd.heater_duty;
    assign repeat_on     = out_res.cmd.repeat_on;
    assign preset_number = out_res.cmd.preset_number;
    assign sound_number  = out_res.cmd.sound_number;

    // A job is never written into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(push && q_stat.full))
        else $error("job pushed into full queue");

    // A job is never taken from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !q_stat.nonempty))
        else $error("job popped from empty queue");

    // Intake stalls only because the queue has no room.
    assert property (@(posedge clk) disable iff (!rst_n) !rx_ready |-> q_stat.full)
        else $error("rx stalled with queue room");

    // The volume marker is always followed at once by the final volume beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && kind == KIND_MORE |=> out_valid && kind == KIND_LAST)
        else $error("volume marker without following volume beat");

endmodule
